### hw/rtl/tahq_pkg.sv
// Package for the timed action heap queue: beat structs, codes and states.
// No dependencies.
`default_nettype none
package tahq_pkg;

    localparam logic [1:0] FUNC_PUSH   = 2'd0;
    localparam logic [1:0] FUNC_RUN    = 2'd1;
    localparam logic [1:0] FUNC_REMOVE = 2'd2;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam logic [2:0] KIND_PUSH_OK     = 3'd0;
    localparam logic [2:0] KIND_PUSH_FULL   = 3'd1;
    localparam logic [2:0] KIND_DUE         = 3'd2;
    localparam logic [2:0] KIND_RUN_DONE    = 3'd3;
    localparam logic [2:0] KIND_REMOVE_DONE = 3'd4;

    // one heap entry as held in memory
    typedef struct packed {
        logic [63:0] due;
        logic [9:0]  owner;
        logic [7:0]  action;
    } entry_t;

    localparam int ENTRY_W = 82;

    typedef struct packed {
        logic [1:0]  func;
        logic [9:0]  owner_id;
        logic [7:0]  action_code;
        logic [63:0] exec_time;
        logic [63:0] current_time;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [9:0]  owner_id_out;
        logic [7:0]  action_code_out;
        logic [63:0] due_time_out;
        logic [63:0] time_until_next;
        logic [5:0]  entry_total;
        logic        last;
    } out_beat_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_UP_RD,
        ST_UP_CMP,
        ST_RUN_TOP,
        ST_RUN_CHK,
        ST_RUN_TAIL,
        ST_RUN_WAIT,
        ST_DN_RD,
        ST_DN_L,
        ST_DN_R,
        ST_DN_CMP,
        ST_RM_RD,
        ST_RM_WAIT,
        ST_RM_CHK,
        ST_BLD_NEXT,
        ST_TOP_RD,
        ST_TOP_WAIT,
        ST_CLOSE,
        ST_EMIT
    } state_t;

endpackage
`default_nettype wire

### hw/rtl/tahq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module tahq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### hw/rtl/timed_action_heap_queue.sv
// Top level of the timed action heap queue: control sequencer around one heap RAM.
// Depends on tahq_pkg and tahq_ram.
//
// Usage: commands arrive on in_valid/in_ready as in_beat_t beats; results leave
// on out_valid/out_ready as out_beat_t beats, the final one of each command
// flagged by last. One command is worked on at a time; in_ready is high only
// while the sequencer is idle and the output register is empty or draining.
// Entries live in one RAM with registered read.
// A push sifts the new entry up from the first free slot, climbing up to 5 levels
// at 32 entries. A run pops each due entry in turn, moves the last entry to the
// root and sifts it down. A remove compacts the surviving entries in order, then
// sifts down each inner node from the last one back to the root, then closes.
// Each result beat sits in the output register; when the receiver stalls the
// sequencer waits on it.
// Reset empties the heap at once (entry count cleared), no clearing pass;
// RAM contents are undefined until written, and a read past the count is never used.
// func 3 is dropped with no result.
`default_nettype none
module timed_action_heap_queue #(
    parameter int CAPACITY = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire tahq_pkg::in_beat_t in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output tahq_pkg::out_beat_t     out_data
);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    tahq_pkg::state_t state_reg, state_next, ret_reg, ret_next;
    tahq_pkg::in_beat_t cmd_reg, cmd_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;      // working slot
    logic [CW-1:0] wr_reg, wr_next;        // compaction write pointer / build index
    tahq_pkg::entry_t cur_reg, cur_next;   // entry being moved
    tahq_pkg::entry_t best_reg, best_next; // best child so far
    logic [CW-1:0] bidx_reg, bidx_next;
    tahq_pkg::out_beat_t obuf_reg, obuf_next;
    logic ovalid_reg, ovalid_next;

    logic ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    tahq_pkg::entry_t ram_wdata, ram_rdata;
    logic [tahq_pkg::ENTRY_W-1:0] rd_raw;
    logic [CW:0] lchild;
    logic [CW-1:0] parent;
    logic [63:0] now;

    tahq_ram #(.WIDTH(tahq_pkg::ENTRY_W), .DEPTH(CAPACITY)) u_heap (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(rd_raw)
    );
    assign ram_rdata = rd_raw;

    assign in_ready  = (state_reg == tahq_pkg::ST_IDLE) && (!ovalid_reg || out_ready);
    assign out_valid = ovalid_reg;
    assign out_data  = obuf_reg;
    assign now       = cmd_reg.current_time;
    assign lchild    = {idx_reg, 1'b1};
    assign parent    = (idx_reg - CW'(1)) >> 1;

    // state and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= tahq_pkg::ST_IDLE;
            ret_reg    <= tahq_pkg::ST_IDLE;
            count_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ret_reg    <= ret_next;
            count_reg  <= count_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        idx_reg  <= idx_next;
        wr_reg   <= wr_next;
        cur_reg  <= cur_next;
        best_reg <= best_next;
        bidx_reg <= bidx_next;
        obuf_reg <= obuf_next;
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        cmd_next    = cmd_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        wr_next     = wr_reg;
        cur_next    = cur_reg;
        best_next   = best_reg;
        bidx_next   = bidx_reg;
        obuf_next   = obuf_reg;
        ovalid_next = ovalid_reg && !out_ready;
        ram_we      = 1'b0;
        ram_waddr   = idx_reg[AW-1:0];
        ram_wdata   = cur_reg;
        ram_raddr   = idx_reg[AW-1:0];

        case (state_reg)
            tahq_pkg::ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd_next = in_data;
                    obuf_next = '0;
                    case (in_data.func)
                        tahq_pkg::FUNC_PUSH:
                        begin
                            if (count_reg >= CW'(CAPACITY))
                            begin
                                obuf_next.kind = tahq_pkg::KIND_PUSH_FULL;
                                state_next = tahq_pkg::ST_TOP_RD;
                            end
                            else
                            begin
                                obuf_next.kind = tahq_pkg::KIND_PUSH_OK;
                                cur_next = '{due: in_data.exec_time,
                                             owner: in_data.owner_id,
                                             action: in_data.action_code};
                                idx_next = count_reg;
                                count_next = count_reg + CW'(1);
                                state_next = tahq_pkg::ST_UP_RD;
                            end
                        end
                        tahq_pkg::FUNC_RUN:
                        begin
                            state_next = tahq_pkg::ST_RUN_TOP;
                        end
                        tahq_pkg::FUNC_REMOVE:
                        begin
                            obuf_next.kind = tahq_pkg::KIND_REMOVE_DONE;
                            idx_next = '0;
                            wr_next = '0;
                            state_next = tahq_pkg::ST_RM_RD;
                        end
                        default:
                        begin
                            state_next = tahq_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            // sift-up: hole at idx, new entry in cur
            tahq_pkg::ST_UP_RD:
            begin
                if (idx_reg == '0)
                begin
                    ram_we = 1'b1;
                    state_next = tahq_pkg::ST_TOP_RD;
                end
                else
                begin
                    ram_raddr = parent[AW-1:0];
                    state_next = tahq_pkg::ST_UP_CMP;
                end
            end
            tahq_pkg::ST_UP_CMP:
            begin
                if (cur_reg.due < ram_rdata.due)
                begin
                    ram_we = 1'b1;
                    ram_wdata = ram_rdata;
                    idx_next = parent;
                    state_next = tahq_pkg::ST_UP_RD;
                end
                else
                begin
                    ram_we = 1'b1;
                    state_next = tahq_pkg::ST_TOP_RD;
                end
            end

            // run: read top
            tahq_pkg::ST_RUN_TOP:
            begin
                ram_raddr = '0;
                state_next = tahq_pkg::ST_RUN_CHK;
            end
            tahq_pkg::ST_RUN_CHK:
            begin
                if (!ovalid_reg || out_ready)
                begin
                    if (count_reg != '0 && ram_rdata.due <= now)
                    begin
                        obuf_next = '0;
                        obuf_next.kind = tahq_pkg::KIND_DUE;
                        obuf_next.owner_id_out = ram_rdata.owner;
                        obuf_next.action_code_out = ram_rdata.action;
                        obuf_next.due_time_out = ram_rdata.due;
                        obuf_next.entry_total = 6'(count_reg - CW'(1));
                        ovalid_next = 1'b1;
                        count_next = count_reg - CW'(1);
                        ram_raddr = AW'(count_reg - CW'(1));
                        state_next = tahq_pkg::ST_RUN_TAIL;
                    end
                    else
                    begin
                        obuf_next = '0;
                        obuf_next.kind = tahq_pkg::KIND_RUN_DONE;
                        state_next = tahq_pkg::ST_TOP_RD;
                    end
                end
                else
                begin
                    state_next = tahq_pkg::ST_RUN_TOP;
                end
            end
            tahq_pkg::ST_RUN_TAIL:
            begin
                cur_next = ram_rdata;
                idx_next = '0;
                ret_next = tahq_pkg::ST_RUN_TOP;
                state_next = tahq_pkg::ST_DN_RD;
            end

            // sift-down of cur from hole idx
            tahq_pkg::ST_DN_RD:
            begin
                if (lchild < (CW + 1)'(count_reg))
                begin
                    ram_raddr = lchild[AW-1:0];
                    state_next = tahq_pkg::ST_DN_L;
                end
                else
                begin
                    ram_we = (count_reg != '0);
                    state_next = ret_reg;
                end
            end
            tahq_pkg::ST_DN_L:
            begin
                best_next = ram_rdata;
                bidx_next = lchild[CW-1:0];
                if (lchild + (CW + 1)'(1) < (CW + 1)'(count_reg))
                begin
                    ram_raddr = AW'(lchild + (CW + 1)'(1));
                    state_next = tahq_pkg::ST_DN_R;
                end
                else
                begin
                    state_next = tahq_pkg::ST_DN_CMP;
                end
            end
            tahq_pkg::ST_DN_R:
            begin
                if (ram_rdata.due < best_reg.due)
                begin
                    best_next = ram_rdata;
                    bidx_next = bidx_reg + CW'(1);
                end
                state_next = tahq_pkg::ST_DN_CMP;
            end
            tahq_pkg::ST_DN_CMP:
            begin
                ram_we = 1'b1;
                if (best_reg.due < cur_reg.due)
                begin
                    ram_wdata = best_reg;
                    idx_next = bidx_reg;
                    state_next = tahq_pkg::ST_DN_RD;
                end
                else
                begin
                    state_next = ret_reg;
                end
            end

            // remove: compact in order
            tahq_pkg::ST_RM_RD:
            begin
                if (idx_reg < count_reg)
                begin
                    state_next = tahq_pkg::ST_RM_WAIT;
                end
                else
                begin
                    count_next = wr_reg;
                    wr_next = wr_reg >> 1;
                    state_next = tahq_pkg::ST_BLD_NEXT;
                end
            end
            tahq_pkg::ST_RM_WAIT:
            begin
                state_next = tahq_pkg::ST_RM_CHK;
            end
            tahq_pkg::ST_RM_CHK:
            begin
                if (ram_rdata.owner != cmd_reg.owner_id)
                begin
                    ram_we = 1'b1;
                    ram_waddr = wr_reg[AW-1:0];
                    ram_wdata = ram_rdata;
                    wr_next = wr_reg + CW'(1);
                end
                idx_next = idx_reg + CW'(1);
                state_next = tahq_pkg::ST_RM_RD;
            end

            // bottom-up rebuild: wr counts down over inner nodes
            tahq_pkg::ST_BLD_NEXT:
            begin
                if (wr_reg == '0)
                begin
                    state_next = tahq_pkg::ST_TOP_RD;
                end
                else
                begin
                    ram_raddr = AW'(wr_reg - CW'(1));
                    idx_next = wr_reg - CW'(1);
                    wr_next = wr_reg - CW'(1);
                    ret_next = tahq_pkg::ST_BLD_NEXT;
                    state_next = tahq_pkg::ST_RUN_WAIT;
                end
            end
            tahq_pkg::ST_RUN_WAIT:
            begin
                cur_next = ram_rdata;
                state_next = tahq_pkg::ST_DN_RD;
            end

            // closing beat: top entry held on the read port
            tahq_pkg::ST_TOP_RD:
            begin
                ram_raddr = '0;
                state_next = tahq_pkg::ST_TOP_WAIT;
            end
            tahq_pkg::ST_TOP_WAIT:
            begin
                ram_raddr = '0;
                state_next = tahq_pkg::ST_CLOSE;
            end
            tahq_pkg::ST_CLOSE:
            begin
                ram_raddr = '0;
                if (!ovalid_reg || out_ready)
                begin
                    if (count_reg == '0)
                    begin
                        obuf_next.time_until_next = '1;
                    end
                    else if (ram_rdata.due <= now)
                    begin
                        obuf_next.time_until_next = '0;
                    end
                    else
                    begin
                        obuf_next.time_until_next = ram_rdata.due - now;
                    end
                    obuf_next.entry_total = 6'(count_reg);
                    obuf_next.last = 1'b1;
                    ovalid_next = 1'b1;
                    state_next = tahq_pkg::ST_EMIT;
                end
            end
            tahq_pkg::ST_EMIT:
            begin
                state_next = tahq_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = tahq_pkg::ST_IDLE;
            end
        endcase
    end

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count beyond capacity");
    a_accept_free: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> (state_reg == tahq_pkg::ST_IDLE
                                    && (!ovalid_reg || out_ready)))
        else $error("accept outside idle or with a result beat waiting");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("stalled result beat changed");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_next && ovalid_reg && !out_ready) |-> (obuf_next == obuf_reg))
        else $error("pending beat overwritten");
endmodule
`default_nettype wire

### sim/tb_timed_action_heap_queue.sv
// Testbench for the timed action heap queue: push, run and remove beats checked
// against a behavioural heap. Depends on tahq_pkg and timed_action_heap_queue.
`timescale 1ns / 1ps
module tb_timed_action_heap_queue;

    localparam int CAP = 32;
    localparam int STALL_LIMIT = 20000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    tahq_pkg::in_beat_t  in_data = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    tahq_pkg::out_beat_t out_data;

    timed_action_heap_queue #(.CAPACITY(CAP)) uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    always #5 clk = ~clk;

    // behavioural copy of the heap
    tahq_pkg::entry_t    shadow_heap [CAP];
    int                  shadow_count = 0;
    tahq_pkg::in_beat_t  pending_cmds [$];
    tahq_pkg::out_beat_t expected_results [$];
    int                  mismatch_count = 0;
    int                  send_idle_pct = 0;
    int                  recv_stall_pct = 0;
    int                  hold_off_cycles = 0;
    bit                  offer_live = 0;
    int                  quiet_cycles = 0;

    function automatic logic [63:0] next_due_gap(logic [63:0] now);
        if (shadow_count == 0) return '1;
        if (shadow_heap[0].due <= now) return '0;
        return shadow_heap[0].due - now;
    endfunction

    function automatic void swap_entries(int a, int b);
        tahq_pkg::entry_t t;
        t = shadow_heap[a];
        shadow_heap[a] = shadow_heap[b];
        shadow_heap[b] = t;
    endfunction

    function automatic void sink_entry(int idx);
        int i, l, r, best;
        i = idx;
        forever
        begin
            l = 2 * i + 1;
            r = l + 1;
            best = i;
            if (l < shadow_count && shadow_heap[l].due < shadow_heap[best].due) best = l;
            if (r < shadow_count && shadow_heap[r].due < shadow_heap[best].due) best = r;
            if (best == i) return;
            swap_entries(i, best);
            i = best;
        end
    endfunction

    function automatic tahq_pkg::out_beat_t close_beat(logic [2:0] k, logic [63:0] now);
        tahq_pkg::out_beat_t b;
        b = '0;
        b.kind = k;
        b.time_until_next = next_due_gap(now);
        b.entry_total = shadow_count[5:0];
        b.last = 1'b1;
        return b;
    endfunction

    // work out the result beats of one accepted command
    function automatic void apply_command(tahq_pkg::in_beat_t c);
        int i, w;
        tahq_pkg::out_beat_t b;
        tahq_pkg::entry_t e;
        case (c.func)
            tahq_pkg::FUNC_PUSH:
            begin
                if (shadow_count >= CAP)
                    expected_results.push_back(close_beat(tahq_pkg::KIND_PUSH_FULL,
                                                          c.current_time));
                else
                begin
                    i = shadow_count;
                    shadow_count++;
                    shadow_heap[i] = '{c.exec_time, c.owner_id, c.action_code};
                    while (i != 0 && shadow_heap[i].due < shadow_heap[(i - 1) / 2].due)
                    begin
                        swap_entries(i, (i - 1) / 2);
                        i = (i - 1) / 2;
                    end
                    expected_results.push_back(close_beat(tahq_pkg::KIND_PUSH_OK,
                                                          c.current_time));
                end
            end
            tahq_pkg::FUNC_RUN:
            begin
                while (shadow_count != 0 && shadow_heap[0].due <= c.current_time)
                begin
                    e = shadow_heap[0];
                    shadow_count--;
                    shadow_heap[0] = shadow_heap[shadow_count];
                    sink_entry(0);
                    b = '0;
                    b.kind = tahq_pkg::KIND_DUE;
                    b.owner_id_out = e.owner;
                    b.action_code_out = e.action;
                    b.due_time_out = e.due;
                    b.entry_total = shadow_count[5:0];
                    expected_results.push_back(b);
                end
                expected_results.push_back(close_beat(tahq_pkg::KIND_RUN_DONE,
                                                      c.current_time));
            end
            tahq_pkg::FUNC_REMOVE:
            begin
                w = 0;
                for (i = 0; i < shadow_count; i++)
                    if (shadow_heap[i].owner != c.owner_id)
                    begin
                        shadow_heap[w] = shadow_heap[i];
                        w++;
                    end
                shadow_count = w;
                for (i = shadow_count / 2; i > 0; i--) sink_entry(i - 1);
                expected_results.push_back(close_beat(tahq_pkg::KIND_REMOVE_DONE,
                                                      c.current_time));
            end
            default: ;
        endcase
    endfunction

    function automatic tahq_pkg::in_beat_t make_cmd(logic [1:0] f, logic [9:0] own,
                                                    logic [7:0] act, logic [63:0] due,
                                                    logic [63:0] now);
        tahq_pkg::in_beat_t c;
        c.func = f;
        c.owner_id = own;
        c.action_code = act;
        c.exec_time = due;
        c.current_time = now;
        return c;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // random command: mostly small times and few owners so runs and removes bite
    function automatic tahq_pkg::in_beat_t rand_cmd();
        int p;
        logic [63:0] due, now;
        p = $urandom_range(0, 99);
        due = ($urandom_range(0, 9) == 0) ? rand64() : 64'($urandom_range(0, 1000));
        now = ($urandom_range(0, 9) == 0) ? rand64() : 64'($urandom_range(0, 1000));
        if (p < 55)
            return make_cmd(tahq_pkg::FUNC_PUSH, ($urandom_range(0, 4) == 0) ? 10'($urandom)
                            : 10'($urandom_range(0, 3)), 8'($urandom), due, now);
        if (p < 80)
            return make_cmd(tahq_pkg::FUNC_RUN, 10'($urandom), 8'($urandom), rand64(), now);
        if (p < 95)
            return make_cmd(tahq_pkg::FUNC_REMOVE, 10'($urandom_range(0, 4)), 8'($urandom),
                            rand64(), now);
        return make_cmd(tahq_pkg::FUNC_UNUSED, 10'($urandom), 8'($urandom), rand64(),
                        rand64());
    endfunction

    // input acceptance: predict and retire the offered command
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            apply_command(in_data);
            void'(pending_cmds.pop_front());
            offer_live = 1'b0;
        end
    end

    // driver: offers the oldest pending command until it is accepted
    always @(negedge clk)
    begin
        if (rst_n && !offer_live)
        begin
            if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                in_data <= pending_cmds[0];
                offer_live = 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver stall pattern, with a long hold-off when requested
    always @(negedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // monitor: compare each result beat with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result beat %p", out_data);
            end
            else
            begin
                if (out_data !== expected_results[0])
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result mismatch: expected %p got %p",
                                 expected_results[0], out_data);
                end
                void'(expected_results.pop_front());
            end
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(int n, int idle_pct, int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (n) pending_cmds.push_back(rand_cmd());
        wait_drained();
    endtask

    initial
    begin
        int i;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, empty cases, full heap, ties, removals
        pending_cmds.push_back(make_cmd(tahq_pkg::FUNC_RUN, '0, '0, '0, '0));
        pending_cmds.push_back(make_cmd(tahq_pkg::FUNC_REMOVE, 10'd5, '0, '0, '1));
        pending_cmds.push_back(make_cmd(tahq_pkg::FUNC_PUSH, '1, '1, '1, '0));
        pending_cmds.push_back(make_cmd(tahq_pkg::FUNC_PUSH, '0, '0, '0, '1));
        pending_cmds.push_back(make_cmd(tahq_pkg::FUNC_UNUSED, '1, '1, '1, '1));
        pending_cmds.push_back(make_cmd(tahq_pkg::FUNC_PUSH, 10'd7, 8'h55, 64'd50, 64'd10));
        pending_cmds.push_back(make_cmd(tahq_pkg::FUNC_PUSH, 10'd8, 8'haa, 64'd50, 64'd10));
        pending_cmds.push_back(make_cmd(tahq_pkg::FUNC_RUN, '0, '0, '0, 64'd20));
        pending_cmds.push_back(make_cmd(tahq_pkg::FUNC_RUN, '0, '0, '0, 64'd50));
        pending_cmds.push_back(make_cmd(tahq_pkg::FUNC_REMOVE, '1, '0, '0, 64'd3));
        pending_cmds.push_back(make_cmd(tahq_pkg::FUNC_REMOVE, 10'd99, '0, '0, 64'd3));
        for (i = 0; i < CAP + 1; i++)
            pending_cmds.push_back(make_cmd(tahq_pkg::FUNC_PUSH, 10'(i % 3), 8'(i),
                                            64'((i * 7) % 11), 64'd4));
        wait_drained();
        pending_cmds.push_back(make_cmd(tahq_pkg::FUNC_REMOVE, 10'd1, '0, '0, 64'd2));
        pending_cmds.push_back(make_cmd(tahq_pkg::FUNC_RUN, '0, '0, '0, '1));

        // random phases with varying back-pressure
        run_phase(25, 0, 0);
        run_phase(25, 70, 0);
        run_phase(25, 0, 70);
        run_phase(25, 12, 12);

        // long receiver hold-off while commands keep coming
        @(negedge clk);
        hold_off_cycles = 300;
        run_phase(20, 0, 0);

        wait_drained();
        repeat (100) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

### timed_action_heap_queue.f
hw/rtl/tahq_pkg.sv
hw/rtl/tahq_ram.sv
hw/rtl/timed_action_heap_queue.sv
sim/tb_timed_action_heap_queue.sv
